### hw/rtl/ycsl_pkg.sv
// Shared types and constants for the yaw curve servo linearizer.
package ycsl_pkg;

	localparam logic [1:0] REQ_WRITE  = 2'd0;
	localparam logic [1:0] REQ_LOOKUP = 2'd1;
	localparam logic [1:0] REQ_DIRECT = 2'd2;

	localparam logic [2:0] CFG_SERVO_MID = 3'd0;
	localparam logic [2:0] CFG_SERVO_MIN = 3'd1;
	localparam logic [2:0] CFG_SERVO_MAX = 3'd2;
	localparam logic [2:0] CFG_MAX_DEFL  = 3'd3;
	localparam logic [2:0] CFG_DIR_REV   = 3'd4;

	localparam logic [10:0] ANGLE_MID  = 11'd900;
	localparam logic [10:0] ANGLE_SPAN = 11'd500;
	localparam logic [10:0] ANGLE_LOW  = 11'd400;
	localparam logic [10:0] ANGLE_HIGH = 11'd1400;
	localparam logic [3:0]  ANGLE_STEP = 4'd10;
	localparam logic [11:0] SERVO_TOP  = 12'd4095;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [6:0]         entry_index;
		logic signed [31:0] entry_value;
		logic signed [31:0] force_req;
		logic [10:0]        angle_in;
	} in_item_t;

	typedef struct packed {
		logic [10:0] angle;
		logic [11:0] servo_value;
		logic        value_saturated;
	} out_item_t;

	typedef struct packed {
		logic [11:0] servo_mid;
		logic [11:0] servo_min;
		logic [11:0] servo_max;
		logic [8:0]  max_deflection;
		logic        direction_reversed;
	} cfg_t;

	typedef struct packed {
		logic               is_lookup;
		logic signed [31:0] force_req;
		logic [10:0]        angle_in;
	} job_t;

endpackage

### hw/rtl/yaw_curve_servo_linearizer.sv
// Top level of the yaw curve servo linearizer: config registers, curve RAM, front and back.
//
// Turns a yaw force into a tail angle through a stored ascending force curve (one entry per
// 10 decidegrees from 400 to 1390), then into a servo pulse scaled on the min-mid or mid-max
// side. A write item loads one curve entry and gives no result; a lookup item clamps the force
// to the curve ends or binary-searches and interpolates; a direct item maps angle_in as given.
// Throughput: one item at a time in the back end. An interpolated lookup runs a binary search
// on the curve RAM read port (seven steps for 100 entries) and four quotient steps for the
// interpolation; the angle mapping, off the mid angle, uses 24 one-bit steps of the serial
// divider that scales by max_deflection.
// A two-entry queue lets the front take new lookups while a result waits on out_ready.
// A write item is held off until all earlier lookups have finished. The curve RAM has no
// reset; lookups before its entries are written give undefined results. Config writes
// (cfg_index 0..4, others ignored) are always accepted and are meant for idle periods.
module yaw_curve_servo_linearizer #(
	parameter int CURVE_ENTRIES = 100
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  ycsl_pkg::in_item_t   in_item,
	output logic                 out_valid,
	input  logic                 out_ready,
	output ycsl_pkg::out_item_t  out_item,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [2:0]           cfg_index,
	input  logic [11:0]          cfg_data
);
	import ycsl_pkg::*;

	localparam int AW = $clog2(CURVE_ENTRIES);

	cfg_t          cfg_q;
	logic          back_idle, job_valid, job_ready;
	job_t          job;
	logic          ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [31:0]   ram_wdata, ram_rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{servo_mid: 12'd1500, servo_min: 12'd1000, servo_max: 12'd2000,
				max_deflection: 9'd400, direction_reversed: 1'b0};
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_SERVO_MID: cfg_q.servo_mid          <= cfg_data;
				CFG_SERVO_MIN: cfg_q.servo_min          <= cfg_data;
				CFG_SERVO_MAX: cfg_q.servo_max          <= cfg_data;
				CFG_MAX_DEFL:  cfg_q.max_deflection     <= cfg_data[8:0];
				CFG_DIR_REV:   cfg_q.direction_reversed <= cfg_data[0];
				default: ;
			endcase
		end
	end

	ycsl_front #(.CURVE_ENTRIES(CURVE_ENTRIES)) u_front (
		.clk, .arst_n, .in_valid, .in_ready, .in_item,
		.back_idle, .job_valid, .job_ready, .job,
		.ram_we, .ram_waddr, .ram_wdata
	);

	ycsl_ram #(.WIDTH(32), .DEPTH(CURVE_ENTRIES)) u_curve (
		.clk, .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.raddr(ram_raddr), .rdata(ram_rdata)
	);

	ycsl_back #(.CURVE_ENTRIES(CURVE_ENTRIES)) u_back (
		.clk, .arst_n, .cfg(cfg_q), .job_valid, .job_ready, .job,
		.idle(back_idle), .ram_raddr, .ram_rdata,
		.out_valid, .out_ready, .out_item
	);
endmodule

### hw/rtl/ycsl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ycsl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 100,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

### hw/rtl/ycsl_front.sv
// Front end: accepts items, performs curve writes, queues lookup and direct jobs.
module ycsl_front #(
	parameter int CURVE_ENTRIES = 100,
	localparam int AW = $clog2(CURVE_ENTRIES)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  ycsl_pkg::in_item_t in_item,
	input  logic              back_idle,
	output logic              job_valid,
	input  logic              job_ready,
	output ycsl_pkg::job_t    job,
	output logic              ram_we,
	output logic [AW-1:0]     ram_waddr,
	output logic [31:0]       ram_wdata
);
	import ycsl_pkg::*;

	job_t       job_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       is_wr, is_job, accept, push, pop;

	assign is_wr  = in_item.req_type == REQ_WRITE;
	assign is_job = in_item.req_type == REQ_LOOKUP || in_item.req_type == REQ_DIRECT;
	// writes wait for all earlier jobs so lookups see the curve in item order
	assign in_ready = is_wr ? (cnt_q == 2'd0 && back_idle) : (cnt_q != 2'd2);
	assign accept = in_valid && in_ready;
	assign push   = accept && is_job;
	assign pop    = job_valid && job_ready;

	assign ram_we    = accept && is_wr && ({1'b0, in_item.entry_index} < 8'(CURVE_ENTRIES));
	assign ram_waddr = in_item.entry_index[AW-1:0];
	assign ram_wdata = in_item.entry_value;

	assign job_valid = cnt_q != 2'd0;
	assign job       = job_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			job_q[wp_q] <= '{is_lookup: in_item.req_type == REQ_LOOKUP,
				force_req: in_item.force_req, angle_in: in_item.angle_in};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

### hw/rtl/ycsl_back.sv
// Back end: curve search, interpolation, and angle to servo mapping.
module ycsl_back #(
	parameter int CURVE_ENTRIES = 100,
	localparam int AW = $clog2(CURVE_ENTRIES)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ycsl_pkg::cfg_t     cfg,
	input  logic               job_valid,
	output logic               job_ready,
	input  ycsl_pkg::job_t     job,
	output logic               idle,
	output logic [AW-1:0]      ram_raddr,
	input  logic [31:0]        ram_rdata,
	output logic               out_valid,
	input  logic               out_ready,
	output ycsl_pkg::out_item_t out_item
);
	import ycsl_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_RD0, S_RD1, S_ENDS, S_CLAMP, S_SRCH, S_CMP,
		S_DIVI, S_DIV, S_MAP, S_MDIV, S_FIN, S_OUT
	} state_t;

	state_t             state_q;
	logic signed [31:0] force_q, lo_val_q, hi_val_q;
	logic [AW-1:0]      lower_q, higher_q, mid_q;
	logic [36:0]        num_q, den_q;
	logic [3:0]         iq_q;
	logic [1:0]         icnt_q;
	logic [10:0]        angle_q;
	logic signed [24:0] prod_q;
	logic [23:0]        quo_q;
	logic [9:0]         rem_q;
	logic [4:0]         mcnt_q;

	logic [AW:0]        sum;
	logic [AW-1:0]      m;
	logic               more;
	logic signed [32:0] fdiff, vdiff;
	logic [10:0]        adiff;
	logic               max_side;
	logic [11:0]        target;
	logic signed [12:0] delta;
	logic [8:0]         range;
	logic [9:0]         rem_sh;
	logic [9:0]         range_x;
	logic signed [25:0] v;
	logic [10:0]        base;

	assign sum  = {1'b0, lower_q} + {1'b0, higher_q};
	assign m    = sum[AW:1];
	assign more = {1'b0, higher_q} > ({1'b0, lower_q} + {{AW{1'b0}}, 1'b1});

	assign fdiff = 33'(force_q) - 33'(lo_val_q);
	assign vdiff = 33'(hi_val_q) - 33'(lo_val_q);

	assign adiff    = (angle_q < ANGLE_MID) ? ANGLE_MID - angle_q : angle_q - ANGLE_MID;
	assign max_side = (angle_q < ANGLE_MID) ? cfg.direction_reversed : !cfg.direction_reversed;
	assign target   = max_side ? cfg.servo_max : cfg.servo_min;
	assign delta    = $signed({1'b0, target}) - $signed({1'b0, cfg.servo_mid});
	assign range    = (cfg.max_deflection == 9'd0) ? 9'd1 : cfg.max_deflection;
	assign range_x  = {1'b0, range};
	assign rem_sh   = {rem_q[8:0], quo_q[23]};

	assign v = $signed({14'd0, cfg.servo_mid})
		+ (prod_q[24] ? -$signed({2'b0, quo_q}) : $signed({2'b0, quo_q}));

	assign base = ANGLE_LOW + 11'({4'd0, lower_q} * 11'(ANGLE_STEP));

	always_comb begin
		case (state_q)
			S_RD0:   ram_raddr = '0;
			S_RD1:   ram_raddr = AW'(CURVE_ENTRIES - 1);
			S_SRCH:  ram_raddr = m;
			default: ram_raddr = m;
		endcase
	end

	assign job_ready = state_q == S_IDLE;
	assign idle      = state_q == S_IDLE;
	assign out_valid = state_q == S_OUT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			force_q  <= '0;
			lo_val_q <= '0;
			hi_val_q <= '0;
			lower_q  <= '0;
			higher_q <= '0;
			mid_q    <= '0;
			num_q    <= '0;
			den_q    <= '0;
			iq_q     <= '0;
			icnt_q   <= '0;
			angle_q  <= '0;
			prod_q   <= '0;
			quo_q    <= '0;
			rem_q    <= '0;
			mcnt_q   <= '0;
			out_item <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (job_valid) begin
						force_q <= job.force_req;
						angle_q <= job.angle_in;
						state_q <= job.is_lookup ? S_RD0 : S_MAP;
					end
				end
				S_RD0: state_q <= S_RD1;
				S_RD1: begin
					lo_val_q <= $signed(ram_rdata);
					state_q  <= S_ENDS;
				end
				S_ENDS: begin
					hi_val_q <= $signed(ram_rdata);
					lower_q  <= '0;
					higher_q <= AW'(CURVE_ENTRIES - 1);
					state_q  <= S_CLAMP;
				end
				S_CLAMP: begin
					if (force_q < lo_val_q) begin
						angle_q <= ANGLE_LOW;
						state_q <= S_MAP;
					end else if (force_q >= hi_val_q) begin
						angle_q <= ANGLE_HIGH;
						state_q <= S_MAP;
					end else begin
						state_q <= S_SRCH;
					end
				end
				S_SRCH: begin
					mid_q   <= m;
					state_q <= more ? S_CMP : S_DIVI;
				end
				S_CMP: begin
					if ($signed(ram_rdata) > force_q) begin
						higher_q <= mid_q;
						hi_val_q <= $signed(ram_rdata);
					end else begin
						lower_q  <= mid_q;
						lo_val_q <= $signed(ram_rdata);
					end
					state_q <= S_SRCH;
				end
				S_DIVI: begin
					// quotient is below ten: four restoring steps
					num_q   <= ({4'd0, fdiff} << 3) + ({4'd0, fdiff} << 1);
					den_q   <= {1'b0, vdiff, 3'd0};
					iq_q    <= '0;
					icnt_q  <= 2'd3;
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (num_q >= den_q) begin
						num_q <= num_q - den_q;
						iq_q  <= {iq_q[2:0], 1'b1};
					end else begin
						iq_q  <= {iq_q[2:0], 1'b0};
					end
					den_q  <= den_q >> 1;
					icnt_q <= icnt_q - 2'd1;
					if (icnt_q == 2'd0) begin
						state_q <= S_FIN;
						mcnt_q  <= 5'd31;
					end
				end
				S_MAP: begin
					prod_q <= $signed({1'b0, adiff}) * delta;
					if (angle_q == ANGLE_MID) begin
						out_item <= '{angle: angle_q, servo_value: cfg.servo_mid,
							value_saturated: 1'b0};
						state_q  <= S_OUT;
					end else begin
						mcnt_q  <= 5'd0;
						state_q <= S_MDIV;
					end
				end
				S_MDIV: begin
					if (mcnt_q == 5'd0) begin
						// load magnitude of the product
						quo_q  <= prod_q[24] ? 24'(-prod_q) : prod_q[23:0];
						rem_q  <= '0;
						mcnt_q <= 5'd24;
					end else begin
						if (rem_sh >= range_x) begin
							rem_q <= rem_sh - range_x;
							quo_q <= {quo_q[22:0], 1'b1};
						end else begin
							rem_q <= rem_sh;
							quo_q <= {quo_q[22:0], 1'b0};
						end
						mcnt_q <= mcnt_q - 5'd1;
						if (mcnt_q == 5'd1) begin
							state_q <= S_FIN;
						end
					end
				end
				S_FIN: begin
					if (mcnt_q == 5'd31) begin
						// interpolation done, go map the angle
						angle_q <= base + {7'd0, iq_q};
						state_q <= S_MAP;
					end else begin
						out_item.angle <= angle_q;
						if (v < 0) begin
							out_item.servo_value     <= '0;
							out_item.value_saturated <= 1'b1;
						end else if (v > $signed({14'd0, SERVO_TOP})) begin
							out_item.servo_value     <= SERVO_TOP;
							out_item.value_saturated <= 1'b1;
						end else begin
							out_item.servo_value     <= v[11:0];
							out_item.value_saturated <= 1'b0;
						end
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
